[hw/rtl/learnable_autorange_normalizer_core_macros.svh]
// Assertion macros for the auto-ranging normaliser core.
// No dependencies.
`ifndef LEARNABLE_AUTORANGE_NORMALIZER_CORE_MACROS_SVH
`define LEARNABLE_AUTORANGE_NORMALIZER_CORE_MACROS_SVH
`define LAN_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define LAN_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[hw/rtl/lan_pkg.sv]
// Package for the auto-ranging normaliser: word types, codes, constants.
// No dependencies.
package lan_pkg;
  localparam int SlotsDef = 8;
  localparam int MaxResults = 8;
  localparam logic signed [31:0] LearnLowQ = 32'sd8323072;
  localparam logic signed [31:0] LearnHighQ = 32'sd0;
  localparam logic signed [32:0] OneQ = 33'sd65536;

  typedef enum logic [1:0] {
    REQ_MSG = 2'd0, REQ_LEARN = 2'd1, REQ_LOW = 2'd2, REQ_HIGH = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [31:0] path_key;
    logic [2:0] slot_index;
    logic learn_enable;
    logic signed [31:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0] out_slot;
    logic [16:0] normalized;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic out_of_range;
    logic last;
  } out_word_t;

  // job handed from front to back: one result per entry
  typedef struct packed {
    logic [2:0] slot;
    logic signed [31:0] raw;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic last;
  } job_t;

  typedef enum logic [1:0] {BK_IDLE, BK_DIV, BK_OUT} bk_state_t;
endpackage

[hw/rtl/lan_front.sv]
// Front end: slot bank state, key match and one job per emitted result.
// Depends on lan_pkg.
module lan_front #(
  parameter int SLOTS = lan_pkg::SlotsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  lan_pkg::in_word_t in_data,
  output logic job_valid,
  input  logic job_full,
  output lan_pkg::job_t job
);
  import lan_pkg::*;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(MaxResults + 1);

  logic learning_armed_r, learning_armed_nxt;
  logic [SLOTS-1:0] pend_r, bound_r, hit_r;
  logic [31:0] key_r [SLOTS];
  logic signed [31:0] lo_r [SLOTS];
  logic signed [31:0] hi_r [SLOTS];
  logic signed [31:0] raw_r [SLOTS];
  logic busy_r;
  logic [SW-1:0] scan_r;
  logic [CW-1:0] cnt_r;
  logic [SLOTS-1:0] bind_v, match_v;
  logic take;
  logic [SLOTS-1:0] rem;
  logic more;
  logic issue;

  assign take = in_push && !in_full;
  assign in_full = busy_r;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      bind_v[i] = learning_armed_r && pend_r[i];
      match_v[i] = (bound_r[i] || bind_v[i]) &&
                   ((bind_v[i] ? in_data.path_key : key_r[i]) == in_data.path_key);
    end
  end

  // any further hit above the scan point, within result room
  always_comb begin
    for (int i = 0; i < SLOTS; i++) rem[i] = hit_r[i] && (i > int'(scan_r));
    more = (|rem) && (cnt_r + CW'(1) < CW'(MaxResults));
  end

  assign issue = busy_r && hit_r[scan_r] && !job_full;
  assign job_valid = issue;
  always_comb begin
    job.slot = 3'(scan_r);
    job.raw = raw_r[scan_r];
    job.lo = lo_r[scan_r];
    job.hi = hi_r[scan_r];
    job.last = !more;
  end

  always_comb begin
    learning_armed_nxt = learning_armed_r;
    if (take && in_data.req_type == REQ_MSG) learning_armed_nxt = 1'b0;
    if (take && in_data.req_type == REQ_LEARN && 32'(in_data.slot_index) < SLOTS &&
        in_data.learn_enable) learning_armed_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_armed_r <= 1'b0;
      pend_r <= '0;
      bound_r <= '0;
      hit_r <= '0;
      busy_r <= 1'b0;
      scan_r <= '0;
      cnt_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        key_r[i] <= '0;
        lo_r[i] <= '0;
        hi_r[i] <= '0;
        raw_r[i] <= '0;
      end
    end else begin
      learning_armed_r <= learning_armed_nxt;
      if (take) begin
        scan_r <= '0;
        cnt_r <= '0;
        if (in_data.req_type == REQ_MSG) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (bind_v[i]) begin
              pend_r[i] <= 1'b0;
              bound_r[i] <= 1'b1;
              key_r[i] <= in_data.path_key;
            end
            if (match_v[i]) begin
              if (in_data.sample_value < lo_r[i]) lo_r[i] <= in_data.sample_value;
              if (in_data.sample_value > hi_r[i]) hi_r[i] <= in_data.sample_value;
              raw_r[i] <= in_data.sample_value;
            end
          end
          hit_r <= match_v;
          busy_r <= |match_v;
        end else if (32'(in_data.slot_index) < SLOTS) begin
          hit_r <= '0;
          if (in_data.req_type == REQ_LEARN) begin
            pend_r[SW'(in_data.slot_index)] <= in_data.learn_enable;
            if (in_data.learn_enable) begin
              lo_r[SW'(in_data.slot_index)] <= LearnLowQ;
              hi_r[SW'(in_data.slot_index)] <= LearnHighQ;
            end
          end else begin
            hit_r[SW'(in_data.slot_index)] <= 1'b1;
            busy_r <= 1'b1;
            if (in_data.req_type == REQ_LOW) lo_r[SW'(in_data.slot_index)] <= in_data.sample_value;
            else hi_r[SW'(in_data.slot_index)] <= in_data.sample_value;
          end
        end
      end else if (busy_r) begin
        if (!hit_r[scan_r]) begin
          scan_r <= scan_r + SW'(1);
        end else if (!job_full) begin
          cnt_r <= cnt_r + CW'(1);
          hit_r[scan_r] <= 1'b0;
          if (!more) begin
            busy_r <= 1'b0;
          end else begin
            scan_r <= scan_r + SW'(1);
          end
        end
      end
    end
  end
endmodule

[hw/rtl/lan_queue.sv]
// Short job queue between front and back ends.
// Depends on lan_pkg.
module lan_queue #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  output logic full,
  input  lan_pkg::job_t wdata,
  input  logic rd,
  output logic empty,
  output lan_pkg::job_t rdata
);
  import lan_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  job_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] n_r;

  assign full = (n_r == (AW+1)'(DEPTH));
  assign empty = (n_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r <= '0;
    end else begin
      if (wr && !full) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      if (rd && !empty) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      n_r <= n_r + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end
endmodule

[hw/rtl/lan_back.sv]
// Back end: serial restoring divider and result register.
// Depends on lan_pkg.
module lan_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_empty,
  output logic job_pop,
  input  lan_pkg::job_t job,
  output logic out_empty,
  input  logic out_pop,
  output lan_pkg::out_word_t out_data
);
  import lan_pkg::*;
  bk_state_t st_r, st_nxt;
  logic [4:0] it_r;
  logic [32:0] ad_r;
  logic [33:0] rem_r;
  logic [16:0] q_r;
  logic [16:0] an_lo_r;
  out_word_t res_r;
  logic signed [32:0] n, d;
  logic [32:0] an, ad;
  logic neg, over;
  logic [33:0] trial;
  logic start;

  always_comb begin
    n = 33'(job.raw) - 33'(job.lo);
    d = 33'(job.hi) - 33'(job.lo);
    if (d == '0) d = OneQ;
    an = n[32] ? 33'(-n) : 33'(n);
    ad = d[32] ? 33'(-d) : 33'(d);
    neg = (n != '0) && (n[32] != d[32]);
    over = an > ad;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (!job_empty) st_nxt = (neg || over) ? BK_OUT : BK_DIV;
      BK_DIV: if (it_r == 5'd16) st_nxt = BK_OUT;
      BK_OUT: if (out_pop) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    start = (st_r == BK_IDLE) && !job_empty;
    out_empty = (st_r != BK_OUT);
    job_pop = (st_r == BK_OUT) && out_pop;
    trial = {rem_r[32:0], an_lo_r[16]} - {1'b0, ad_r};
    out_data = res_r;
    out_data.normalized = (st_r == BK_OUT && !res_r.out_of_range && res_r.normalized == '0)
                          ? q_r : res_r.normalized;
  end

  // dividend is an*2^16: start from an>>1, then shift in an[0] and 16 zeros.
  // quotient fits 17 bits since an <= ad
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BK_IDLE;
    else st_r <= st_nxt;
    if (start) begin
      it_r <= '0;
      ad_r <= ad;
      rem_r <= {2'd0, an[32:1]};
      an_lo_r <= {an[0], 16'd0};
      q_r <= '0;
      res_r.out_slot <= job.slot;
      res_r.low_bound <= job.lo;
      res_r.high_bound <= job.hi;
      res_r.last <= job.last;
      res_r.out_of_range <= neg || over;
      res_r.normalized <= neg ? 17'd0 : (over ? 17'(OneQ) : 17'd0);
    end else if (st_r == BK_DIV) begin
      it_r <= it_r + 5'd1;
      an_lo_r <= {an_lo_r[15:0], 1'b0};
      if (!trial[33]) begin
        rem_r <= trial;
        q_r <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= {rem_r[32:0], an_lo_r[16]};
        q_r <= {q_r[15:0], 1'b0};
      end
    end
  end
endmodule

[hw/rtl/learnable_autorange_normalizer_core.sv]
// Top level of the auto-ranging normaliser: front end, job queue, back end.
// Depends on lan_pkg, lan_front, lan_queue, lan_back and the macros header.
// channel | ports                     | word
// input   | in_push in_full in_data   | in_word_t
// output  | out_empty out_pop out_data| out_word_t
// An in-range result goes through the back end as load, 17 one-bit steps, then output.
// A saturated result skips the divider and goes from load straight to output.
// A message that hits a slot holds in_full high while the front scans the slots, plus queue waits.
// Reset (rst_n low, synchronous) clears all slots, the queue and the back-end state machine.
// The front stalls when the job queue is full; the back stalls on out_pop.
`include "learnable_autorange_normalizer_core_macros.svh"
module learnable_autorange_normalizer_core #(
  parameter int SLOTS = lan_pkg::SlotsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  lan_pkg::in_word_t in_data,
  output logic out_empty,
  input  logic out_pop,
  output lan_pkg::out_word_t out_data
);
  import lan_pkg::*;
  logic jv, jfull, jempty, jpop;
  job_t jw, jr;

  lan_front #(.SLOTS(SLOTS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .job_valid(jv), .job_full(jfull), .job(jw)
  );
  lan_queue #(.DEPTH(2)) u_queue (
    .clk, .rst_n, .wr(jv), .full(jfull), .wdata(jw),
    .rd(jpop), .empty(jempty), .rdata(jr)
  );
  lan_back u_back (
    .clk, .rst_n, .job_empty(jempty), .job_pop(jpop), .job(jr),
    .out_empty, .out_pop, .out_data
  );

  `LAN_ASSERT_IMP(a_sat_val, clk, rst_n, !out_empty && out_data.out_of_range, out_data.normalized == 17'd0 || out_data.normalized == 17'd65536, "saturated word not at 0 or 1")
  `LAN_ASSERT_IMP(a_norm_max, clk, rst_n, !out_empty, out_data.normalized <= 17'd65536, "normalised value above one")
  `LAN_ASSERT_NXT(a_pop_drop, clk, rst_n, !out_empty && out_pop, out_empty, "result word held after pop")
endmodule

[tb/testbench.sv]
// Self-checking testbench for the auto-ranging normaliser core.
// Depends on lan_pkg and learnable_autorange_normalizer_core; stimulus is directed then random.
`timescale 1ns / 100ps
module testbench;
  import lan_pkg::*;

  localparam int NSLOT = 8;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_word_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_word_t out_data;

  learnable_autorange_normalizer_core dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic armed;
  logic pend [NSLOT];
  logic bound [NSLOT];
  logic [31:0] key_of [NSLOT];
  logic signed [31:0] lo_of [NSLOT];
  logic signed [31:0] hi_of [NSLOT];
  logic signed [31:0] raw_of [NSLOT];

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  logic [31:0] keys [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};

  function automatic out_word_t normalise(int s);
    out_word_t w;
    logic signed [63:0] n, d, an, ad;
    n = 64'(raw_of[s]) - 64'(lo_of[s]);
    d = 64'(hi_of[s]) - 64'(lo_of[s]);
    if (d == 0) d = 64'(OneQ);
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    w = '0;
    w.out_slot = 3'(s);
    w.low_bound = lo_of[s];
    w.high_bound = hi_of[s];
    if (n != 0 && ((n < 0) != (d < 0))) begin
      w.normalized = '0;
      w.out_of_range = 1'b1;
    end else if (an > ad) begin
      w.normalized = 17'(OneQ);
      w.out_of_range = 1'b1;
    end else begin
      w.normalized = 17'((an <<< 16) / ad);
      w.out_of_range = 1'b0;
    end
    return w;
  endfunction

  task automatic predict_word(input in_word_t w);
    out_word_t res[$];
    if (w.req_type == REQ_MSG) begin
      if (armed) begin
        for (int i = 0; i < NSLOT; i++)
          if (pend[i]) begin
            pend[i] = 1'b0;
            key_of[i] = w.path_key;
            bound[i] = 1'b1;
          end
        armed = 1'b0;
      end
      for (int i = 0; i < NSLOT; i++)
        if (bound[i] && key_of[i] == w.path_key) begin
          if (w.sample_value < lo_of[i]) lo_of[i] = w.sample_value;
          if (w.sample_value > hi_of[i]) hi_of[i] = w.sample_value;
          raw_of[i] = w.sample_value;
          if (res.size() < MaxResults) res.push_back(normalise(i));
        end
    end else if (w.req_type == REQ_LEARN) begin
      pend[w.slot_index] = w.learn_enable;
      if (w.learn_enable) begin
        armed = 1'b1;
        lo_of[w.slot_index] = LearnLowQ;
        hi_of[w.slot_index] = LearnHighQ;
      end
    end else begin
      if (w.req_type == REQ_LOW) lo_of[w.slot_index] = w.sample_value;
      else hi_of[w.slot_index] = w.sample_value;
      res.push_back(normalise(w.slot_index));
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[k]) expected_words.push_back(res[k]);
  endtask

  function automatic in_word_t make_word(req_t r, logic [31:0] k, int s, bit en,
                                         logic signed [31:0] v);
    in_word_t w;
    w.req_type = r;
    w.path_key = k;
    w.slot_index = 3'(s);
    w.learn_enable = en;
    w.sample_value = v;
    return w;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(0, 200) << 16)) - 32'sd6553600;
      default: return $signed($urandom());
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_word(in_data);
        void'(pending_words.pop_front());
      end
      if (in_push && in_full) begin
        // keep offering the same word
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_push <= 1'b0;
      end else if (!hold_off && pending_words.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          tx_gap <= $urandom_range(0, 4);
          in_push <= 1'b0;
        end else begin
          in_push <= 1'b1;
          in_data <= pending_words[0];
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word %h", out_data);
          errors++;
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          if (out_data.out_slot !== e.out_slot) begin
            $error("out_slot exp %0d got %0d", e.out_slot, out_data.out_slot); errors++;
          end
          if (out_data.normalized !== e.normalized) begin
            $error("normalized exp %0d got %0d", e.normalized, out_data.normalized); errors++;
          end
          if (out_data.low_bound !== e.low_bound) begin
            $error("low_bound exp %0d got %0d", e.low_bound, out_data.low_bound); errors++;
          end
          if (out_data.high_bound !== e.high_bound) begin
            $error("high_bound exp %0d got %0d", e.high_bound, out_data.high_bound); errors++;
          end
          if (out_data.out_of_range !== e.out_of_range) begin
            $error("out_of_range exp %0d got %0d", e.out_of_range, out_data.out_of_range);
            errors++;
          end
          if (out_data.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_data.last); errors++;
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rx_gap <= $urandom_range(0, 4);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    armed = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      pend[i] = 1'b0; bound[i] = 1'b0; key_of[i] = '0;
      lo_of[i] = '0; hi_of[i] = '0; raw_of[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unbound message, writes at extremes, learn, bind, match all slots but one
    pending_words.push_back(make_word(REQ_MSG, 32'h0, 0, 1'b0, 32'sd5));
    pending_words.push_back(make_word(REQ_LOW, 32'hFFFF_FFFF, 7, 1'b1, 32'sh8000_0000));
    pending_words.push_back(make_word(REQ_HIGH, 32'h0, 7, 1'b0, 32'sh7FFF_FFFF));
    pending_words.push_back(make_word(REQ_HIGH, 32'h0, 0, 1'b0, 32'sd0)); // high equals low
    pending_words.push_back(make_word(REQ_LOW, 32'h0, 3, 1'b0, 32'sd100000)); // high below low
    for (int i = 0; i < NSLOT; i++)
      pending_words.push_back(make_word(REQ_LEARN, 32'h0, i, 1'b1, 32'sd0));
    pending_words.push_back(make_word(REQ_LEARN, 32'h0, 5, 1'b0, 32'sd0)); // clear one flag
    pending_words.push_back(make_word(REQ_MSG, 32'hFFFF_FFFF, 0, 1'b0, 32'sd65536));
    pending_words.push_back(make_word(REQ_MSG, 32'hFFFF_FFFF, 0, 1'b0, 32'sh8000_0000));
    pending_words.push_back(make_word(REQ_MSG, 32'hFFFF_FFFF, 0, 1'b0, 32'sh7FFF_FFFF));
    pending_words.push_back(make_word(REQ_MSG, 32'hFFFF_FFFF, 0, 1'b0, 32'sd0));
    pending_words.push_back(make_word(REQ_LEARN, 32'h0, 5, 1'b0, 32'sd0));
    pending_words.push_back(make_word(REQ_MSG, 32'h1, 0, 1'b0, 32'sd7));
    wait (pending_words.size() == 0 && !in_push);

    // pause until all results are back
    hold_off = 1'b1;
    wait (expected_words.size() == 0);
    repeat (60) @(posedge clk);
    hold_off = 1'b0;

    for (int n = 0; n < 300; n++) begin
      int r;
      r = $urandom_range(0, 9);
      if (r < 2)
        pending_words.push_back(make_word(REQ_LEARN, $urandom(), $urandom_range(0, 7),
                                          $urandom_range(0, 3) != 0, $signed($urandom())));
      else if (r < 7)
        pending_words.push_back(make_word(REQ_MSG, r == 6 ? $urandom() : keys[$urandom_range(0, 3)],
                                          $urandom_range(0, 7), $urandom_range(0, 1), rand_value()));
      else
        pending_words.push_back(make_word(r < 9 ? REQ_LOW : REQ_HIGH, $urandom(),
                                          $urandom_range(0, 7), $urandom_range(0, 1), rand_value()));
      if (n == 240) quiet = 1'b1;
      while (pending_words.size() > 4) @(posedge clk);
    end
    wait (pending_words.size() == 0 && !in_push);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[learnable_autorange_normalizer_core.f]
+incdir+hw/rtl
hw/rtl/lan_pkg.sv
hw/rtl/lan_front.sv
hw/rtl/lan_queue.sv
hw/rtl/lan_back.sv
hw/rtl/learnable_autorange_normalizer_core.sv
tb/testbench.sv
